>>> rtl/keyword_ident_number_lexer_assert.svh
// assertion macros used by the lexer checker
`ifndef KEYWORD_IDENT_NUMBER_LEXER_ASSERT_SVH
`define KEYWORD_IDENT_NUMBER_LEXER_ASSERT_SVH

// property checked only while out of reset
`define KWL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define KWL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kwl_pkg.sv
// types, constants and helper functions for the keyword / identifier / number lexer
package kwl_pkg;

    localparam int POSITION_BITS    = 16;
    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int LEN_BITS         = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int START_OUT_BITS   = 16;
    localparam int LENGTH_OUT_BITS  = 8;

    // token queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // keyword lengths
    localparam logic [2:0] KW_LEN_EXIT = 3'd4;
    localparam logic [2:0] KW_LEN_LET  = 3'd3;
    localparam logic [2:0] KW_LEN_BE   = 3'd2;

    // keyword slots in the alive mask
    localparam logic [1:0] KW_EXIT = 2'd0;
    localparam logic [1:0] KW_LET  = 2'd1;
    localparam logic [1:0] KW_BE   = 2'd2;

    // single-byte token characters
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [2:0] {
        KIND_IDENT = 3'd0,
        KIND_EXIT  = 3'd1,
        KIND_LET   = 3'd2,
        KIND_BE    = 3'd3,
        KIND_INT   = 3'd4,
        KIND_OPEN  = 3'd5,
        KIND_CLOSE = 3'd6,
        KIND_SEMI  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind                      kind;
        logic [START_OUT_BITS-1:0]  start;
        logic [LENGTH_OUT_BITS-1:0] length;
        logic                       sat;
        logic                       last;
    } t_token;

    // zero, one or two tokens produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_push;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] res;
        unique case (k)
            KW_EXIT: res = KW_LEN_EXIT;
            KW_LET:  res = KW_LEN_LET;
            KW_BE:   res = KW_LEN_BE;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // character of keyword k at position idx
    function automatic logic [7:0] kw_char(logic [1:0] k, logic [1:0] idx);
        logic [7:0] res;
        res = 8'h00;
        unique case (k)
            KW_EXIT: begin
                unique case (idx)
                    2'd0: res = 8'h65;
                    2'd1: res = 8'h78;
                    2'd2: res = 8'h69;
                    default: res = 8'h74;
                endcase
            end
            KW_LET: begin
                unique case (idx)
                    2'd0: res = 8'h6C;
                    2'd1: res = 8'h65;
                    default: res = 8'h74;
                endcase
            end
            KW_BE: begin
                res = (idx == 2'd0) ? 8'h62 : 8'h65;
            end
            default: res = 8'h00;
        endcase
        return res;
    endfunction

    // drop keywords that are already complete or whose next character does not match
    function automatic logic [2:0] narrow(logic [2:0] alive, logic [LEN_BITS-1:0] len,
                                          logic [7:0] c);
        logic [2:0] res;
        res = alive;
        for (int k = 0; k < 3; k++) begin
            if (len >= LEN_BITS'(kw_len(2'(k))) || kw_char(2'(k), len[1:0]) != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // kind of a pending token from its scan state
    function automatic t_kind pending_kind(t_mode mode, logic [LEN_BITS-1:0] len,
                                           logic ovf, logic [2:0] alive);
        t_kind res;
        res = KIND_IDENT;
        if (mode == MODE_INT) begin
            res = KIND_INT;
        end else if (!ovf) begin
            if (alive[KW_EXIT] && len == LEN_BITS'(KW_LEN_EXIT)) begin
                res = KIND_EXIT;
            end else if (alive[KW_LET] && len == LEN_BITS'(KW_LEN_LET)) begin
                res = KIND_LET;
            end else if (alive[KW_BE] && len == LEN_BITS'(KW_LEN_BE)) begin
                res = KIND_BE;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/kwl_queue.sv
// short token queue between the scanning front and the output back
module kwl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kwl_pkg::t_push  i_push,
    input  logic            i_pop,
    output kwl_pkg::t_token o_head,
    output logic            o_has_data,
    output logic            o_room
);
    import kwl_pkg::*;

    t_token                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr;
    logic [QPTR_BITS-1:0]  r_rd;
    logic [QCNT_BITS-1:0]  r_count;
    logic [QPTR_BITS-1:0]  w_wr_next;

    assign w_wr_next  = QPTR_BITS'(r_wr + 1'b1);
    assign o_head     = r_mem[r_rd];
    assign o_has_data = (r_count != '0);
    // room for the worst case of two tokens from one byte
    assign o_room     = (r_count <= QCNT_BITS'(QUEUE_DEPTH - 2));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_next] <= i_push.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= QPTR_BITS'(r_wr + i_push.count);
            if (i_pop) begin
                r_rd <= QPTR_BITS'(r_rd + 1'b1);
            end
            r_count <= QCNT_BITS'(r_count + i_push.count - {1'b0, i_pop});
        end
    end

endmodule

>>> rtl/kwl_front.sv
// byte scanner: tracks the pending token and produces finished tokens
module kwl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_byte,
    input  logic           i_end_of_input,
    input  logic           i_room,
    output kwl_pkg::t_push o_push
);
    import kwl_pkg::*;

    t_mode                    r_mode,  n_mode,  s_mode;
    logic [POSITION_BITS-1:0] r_start, n_start, s_start;
    logic [LEN_BITS-1:0]      r_len,   n_len,   s_len;
    logic                     r_ovf,   n_ovf,   s_ovf;
    logic [2:0]               r_alive, n_alive, s_alive;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;

    logic   w_accept;
    logic   w_letter;
    logic   w_digit;
    logic   w_flush_hit;
    logic   w_single_hit;
    logic   w_final_hit;
    logic   w_tail_hit;
    t_kind  w_single_kind;
    t_token w_flush_tok;
    t_token w_single_tok;
    t_token w_final_tok;
    t_token w_tail_tok;

    assign o_ready  = i_room;
    assign w_accept = i_valid && i_room;
    assign w_letter = is_letter(i_char_byte);
    assign w_digit  = is_digit(i_char_byte);

    // scan state update for the accepted byte
    always_comb begin
        s_mode        = r_mode;
        s_start       = r_start;
        s_len         = r_len;
        s_ovf         = r_ovf;
        s_alive       = r_alive;
        w_flush_hit   = 1'b0;
        w_single_hit  = 1'b0;
        w_single_kind = KIND_OPEN;
        if (w_accept) begin
            if (w_letter && r_mode != MODE_IDENT) begin
                // letter opens an identifier, closing any integer
                w_flush_hit = (r_mode != MODE_IDLE);
                s_mode      = MODE_IDENT;
                s_start     = r_pos;
                s_len       = LEN_BITS'(1);
                s_ovf       = 1'b0;
                s_alive     = narrow(3'b111, '0, i_char_byte);
            end else if (w_digit && r_mode == MODE_IDLE) begin
                // digit opens an integer
                s_mode  = MODE_INT;
                s_start = r_pos;
                s_len   = LEN_BITS'(1);
                s_ovf   = 1'b0;
                s_alive = 3'b111;
            end else if (w_letter || w_digit) begin
                // byte extends the pending token
                if (r_mode == MODE_IDENT) begin
                    s_alive = narrow(r_alive, r_len, i_char_byte);
                end
                if (r_len < LEN_BITS'(MAX_TOKEN_LENGTH)) begin
                    s_len = LEN_BITS'(r_len + 1'b1);
                end else begin
                    s_ovf = 1'b1;
                end
            end else begin
                // separator, punctuation or unrecognized byte
                w_flush_hit = (r_mode != MODE_IDLE);
                s_mode      = MODE_IDLE;
                s_len       = '0;
                s_ovf       = 1'b0;
                s_alive     = 3'b111;
                unique case (i_char_byte)
                    CH_OPEN: begin
                        w_single_hit  = 1'b1;
                        w_single_kind = KIND_OPEN;
                    end
                    CH_CLOSE: begin
                        w_single_hit  = 1'b1;
                        w_single_kind = KIND_CLOSE;
                    end
                    CH_SEMI: begin
                        w_single_hit  = 1'b1;
                        w_single_kind = KIND_SEMI;
                    end
                    default: w_single_hit = 1'b0;
                endcase
            end
        end
    end

    // next state, with a return to reset state after the final byte
    always_comb begin
        w_final_hit = 1'b0;
        n_mode      = s_mode;
        n_start     = s_start;
        n_len       = s_len;
        n_ovf       = s_ovf;
        n_alive     = s_alive;
        n_pos       = r_pos;
        if (w_accept) begin
            n_pos = POSITION_BITS'(r_pos + 1'b1);
            if (i_end_of_input) begin
                w_final_hit = (s_mode != MODE_IDLE);
                n_mode      = MODE_IDLE;
                n_start     = '0;
                n_len       = '0;
                n_ovf       = 1'b0;
                n_alive     = 3'b111;
                n_pos       = '0;
            end
        end
    end

    // token records
    always_comb begin
        w_flush_tok.kind   = pending_kind(r_mode, r_len, r_ovf, r_alive);
        w_flush_tok.start  = START_OUT_BITS'(r_start);
        w_flush_tok.length = LENGTH_OUT_BITS'(r_len);
        w_flush_tok.sat    = r_ovf;
        w_flush_tok.last   = 1'b0;

        w_single_tok.kind   = w_single_kind;
        w_single_tok.start  = START_OUT_BITS'(r_pos);
        w_single_tok.length = LENGTH_OUT_BITS'(1);
        w_single_tok.sat    = 1'b0;
        w_single_tok.last   = 1'b1;

        w_final_tok.kind   = pending_kind(s_mode, s_len, s_ovf, s_alive);
        w_final_tok.start  = START_OUT_BITS'(s_start);
        w_final_tok.length = LENGTH_OUT_BITS'(s_len);
        w_final_tok.sat    = s_ovf;
        w_final_tok.last   = 1'b1;

        // a single-byte token and the final flush never come together
        w_tail_hit = w_single_hit || w_final_hit;
        w_tail_tok = w_single_hit ? w_single_tok : w_final_tok;
    end

    // tokens handed to the queue, closed token first
    always_comb begin
        o_push.count  = {1'b0, w_flush_hit} + {1'b0, w_tail_hit};
        o_push.second = w_tail_tok;
        if (w_flush_hit) begin
            o_push.first      = w_flush_tok;
            o_push.first.last = !w_tail_hit;
        end else begin
            o_push.first = w_tail_tok;
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_alive <= 3'b111;
            r_pos   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_alive <= n_alive;
            r_pos   <= n_pos;
        end
    end

endmodule

>>> rtl/kwl_back.sv
// output register: takes tokens from the queue and holds them for the consumer
module kwl_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kwl_pkg::t_token                      i_head,
    input  logic                                 i_has_data,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0]                           o_token_kind,
    output logic [kwl_pkg::START_OUT_BITS-1:0]   o_token_start,
    output logic [kwl_pkg::LENGTH_OUT_BITS-1:0]  o_token_length,
    output logic                                 o_length_saturated,
    output logic                                 o_last_of_run
);
    import kwl_pkg::*;

    logic   r_valid;
    t_token r_tok;

    // load when the register is empty or its token is transferred
    assign o_pop = i_has_data && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_has_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tok <= i_head;
        end
    end

    assign o_valid            = r_valid;
    assign o_token_kind       = r_tok.kind;
    assign o_token_start      = r_tok.start;
    assign o_token_length     = r_tok.length;
    assign o_length_saturated = r_tok.sat;
    assign o_last_of_run      = r_tok.last;

endmodule

>>> rtl/keyword_ident_number_lexer.sv
// top level of the keyword / identifier / number lexer
//
//  channel  | signals                                      | direction
//  ---------+----------------------------------------------+----------
//  byte in  | i_valid, o_ready, i_char_byte, i_end_of_input | input
//  token out| o_valid, i_ready, o_token_kind/start/length,  | output
//           | o_length_saturated, o_last_of_run            |
//
// an accepted byte's tokens pass through the token queue into the output
// register that drives o_valid; bytes are taken back to back while o_ready
// is high; a byte that closes a token and forms a punctuation token yields
// two tokens, which the single output register delivers in turn
// o_ready drops while the four-entry token queue has fewer than two free slots
// synchronous reset clears the scan state, the queue and the output valid
module keyword_ident_number_lexer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_char_byte,
    input  logic                                 i_end_of_input,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0]                           o_token_kind,
    output logic [kwl_pkg::START_OUT_BITS-1:0]   o_token_start,
    output logic [kwl_pkg::LENGTH_OUT_BITS-1:0]  o_token_length,
    output logic                                 o_length_saturated,
    output logic                                 o_last_of_run
);
    import kwl_pkg::*;

    t_push  w_push;
    t_token w_head;
    logic   w_has_data;
    logic   w_room;
    logic   w_pop;

    // byte scanner
    kwl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .i_room         (w_room),
        .o_push         (w_push)
    );

    // token queue
    kwl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_has_data (w_has_data),
        .o_room     (w_room)
    );

    // output register
    kwl_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .i_has_data         (w_has_data),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_token_kind       (o_token_kind),
        .o_token_start      (o_token_start),
        .o_token_length     (o_token_length),
        .o_length_saturated (o_length_saturated),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

>>> rtl/kwl_checker.sv
// port-level checks for the lexer, bound to the top level
`include "keyword_ident_number_lexer_assert.svh"

module kwl_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [2:0]                           o_token_kind,
    input logic [kwl_pkg::START_OUT_BITS-1:0]   o_token_start,
    input logic [kwl_pkg::LENGTH_OUT_BITS-1:0]  o_token_length,
    input logic                                 o_length_saturated,
    input logic                                 o_last_of_run
);
    import kwl_pkg::*;

    logic w_keyword_ok;
    logic w_punct;

    // keyword lengths and the saturation flag per kind
    assign w_keyword_ok = (o_token_kind != KIND_EXIT || o_token_length == 8'd4) &&
                          (o_token_kind != KIND_LET  || o_token_length == 8'd3) &&
                          (o_token_kind != KIND_BE   || o_token_length == 8'd2) &&
                          (o_token_kind == KIND_IDENT || o_token_kind == KIND_INT ||
                           !o_length_saturated);

    assign w_punct = (o_token_kind == KIND_OPEN) || (o_token_kind == KIND_CLOSE) ||
                     (o_token_kind == KIND_SEMI);

    // stalled token keeps valid and payload
    property p_out_hold;
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind) &&
            $stable(o_token_start) && $stable(o_token_length) &&
            $stable(o_length_saturated) && $stable(o_last_of_run);
    endproperty

    // no token shown right after reset
    `KWL_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "token valid after reset")

    // a stalled token holds
    `KWL_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled token changed")

    // keywords carry their exact length and are never saturated
    `KWL_ASSERT(a_keyword_len, i_clk, i_rst_n, o_valid |-> w_keyword_ok, "keyword length mismatch")

    // punctuation tokens are one byte long
    `KWL_ASSERT(a_punct_len, i_clk, i_rst_n, o_valid && w_punct |-> o_token_length == 8'd1 && !o_length_saturated, "punctuation token length wrong")

    // every token has at least one character
    `KWL_ASSERT(a_len_nonzero, i_clk, i_rst_n, o_valid |-> o_token_length != 8'd0, "empty token")

endmodule

bind keyword_ident_number_lexer kwl_checker u_kwl_checker (.*);
